FILE: hw/rtl/rese_pkg.sv
`timescale 1ns / 1ps
package rese_pkg;
   localparam int MAX_SIDE_DEF = 4096;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int COLOR_W      = 8;
   localparam int PCT_W        = 7;
   localparam int SUM_W        = 10;
   localparam int RATIO_W      = 8;
   localparam int WSUM_W       = 8;
   localparam int WEIGHT_W     = 7;
   localparam int SCORE_W      = 15;
   localparam int IDX_W        = 4;
   localparam int TAPER_HALF   = 6;
   localparam int QUEUE_DEPTH  = 2;

   // register map
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_X      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CENTER_Y      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HALF_SPAN     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RED_MIN       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RED_PCT_MIN   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_GREEN_PCT_MAX = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_BLUE_PCT_MAX  = 3'd6;

   localparam logic [COLOR_W-1:0] RED_MIN_RST       = 8'd50;
   localparam logic [PCT_W-1:0]   RED_PCT_MIN_RST   = 7'd40;
   localparam logic [PCT_W-1:0]   GREEN_PCT_MAX_RST = 7'd31;
   localparam logic [PCT_W-1:0]   BLUE_PCT_MAX_RST  = 7'd36;

   typedef struct packed {
      logic [COLOR_W-1:0] red_min;
      logic [PCT_W-1:0]   red_pct_min;
      logic [PCT_W-1:0]   green_pct_max;
      logic [PCT_W-1:0]   blue_pct_max;
   } rese_thr_type;

   // 13-entry taper, peak at the centre index
   function automatic logic [WEIGHT_W-1:0] taper_at(input logic [IDX_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         4'd0, 4'd12: w = 7'd28;
         4'd1, 4'd11: w = 7'd39;
         4'd2, 4'd10: w = 7'd48;
         4'd3, 4'd9:  w = 7'd55;
         4'd4, 4'd8:  w = 7'd60;
         4'd5, 4'd7:  w = 7'd63;
         4'd6:        w = 7'd64;
         default:     w = 7'd28;
      endcase
      return w;
   endfunction
endpackage

FILE: hw/rtl/rese_req_if.sv
`timescale 1ns / 1ps
interface rese_req_if #(parameter int COORD_W = $clog2(rese_pkg::MAX_SIDE_DEF));
   logic                        valid;
   logic                        ready;
   logic [COORD_W-1:0]          pix_x;
   logic [COORD_W-1:0]          pix_y;
   logic [rese_pkg::COLOR_W-1:0] red;
   logic [rese_pkg::COLOR_W-1:0] green;
   logic [rese_pkg::COLOR_W-1:0] blue;
   logic                        last_pixel;
   modport source (output valid, pix_x, pix_y, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, pix_x, pix_y, red, green, blue, last_pixel, output ready);
endinterface

FILE: hw/rtl/rese_rsp_if.sv
`timescale 1ns / 1ps
interface rese_rsp_if #(parameter int COORD_W = $clog2(rese_pkg::MAX_SIDE_DEF));
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [COORD_W-1:0]          best_x;
   logic [COORD_W-1:0]          best_y;
   logic [rese_pkg::SCORE_W-1:0] best_score;
   modport source (output valid, found, best_x, best_y, best_score, input ready);
   modport sink   (input valid, found, best_x, best_y, best_score, output ready);
endinterface

FILE: hw/rtl/rese_csr_if.sv
`timescale 1ns / 1ps
interface rese_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rese_pkg::CSR_ADDR_W-1:0] addr;
   logic [rese_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

FILE: hw/rtl/rese_fifo.sv
`timescale 1ns / 1ps
module rese_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: hw/rtl/rese_front.sv
`timescale 1ns / 1ps
module rese_front #(
   parameter int COORD_W = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   rese_req_if.sink                  req_bus,
   input  rese_pkg::rese_thr_type    thr,
   input  logic [COORD_W-1:0]        center_x,
   input  logic [COORD_W-1:0]        center_y,
   input  logic [COORD_W-1:0]        half_span,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic                      out_hit,
   output logic                      out_last,
   output logic [COORD_W-1:0]        out_x,
   output logic [COORD_W-1:0]        out_y,
   output logic [rese_pkg::COLOR_W-1:0] out_red,
   output logic [rese_pkg::SUM_W-1:0]   out_sum,
   output logic [rese_pkg::WSUM_W-1:0]  out_wsum
);
   import rese_pkg::*;

   localparam int M6_W  = COORD_W + 3;
   localparam int PCT_PROD_W = 17;

   logic                 stg_valid_ff, stg_valid_in;
   logic [COORD_W-1:0]   stg_x_ff, stg_y_ff;
   logic [COLOR_W-1:0]   stg_r_ff, stg_g_ff, stg_b_ff;
   logic                 stg_last_ff;
   logic                 take;
   logic [SUM_W-1:0]     sum;
   logic [PCT_PROD_W-1:0] r100, g100, b100, r_lim, g_lim, b_lim;
   logic [WEIGHT_W-1:0]  wx, wy;

   // offset from centre scaled by 6/half_span, truncated toward zero, clamped
   function automatic logic [WEIGHT_W-1:0] weight_at(
      input logic [COORD_W-1:0] pos,
      input logic [COORD_W-1:0] ctr,
      input logic [COORD_W-1:0] hs
   );
      logic signed [COORD_W:0] off;
      logic                    neg;
      logic [COORD_W:0]        mag;
      logic [M6_W-1:0]         m6;
      logic [2:0]              q;
      logic [IDX_W-1:0]        idx;
      off = $signed({1'b0, pos}) - $signed({1'b0, ctr});
      neg = off[COORD_W];
      mag = neg ? (~off + 1'b1) : off;
      m6  = (M6_W'(mag) << 2) + (M6_W'(mag) << 1);
      q   = '0;
      // quotient digit count: one compare per multiple of half_span
      for (int k = 1; k <= TAPER_HALF; k++) begin
         if (m6 >= M6_W'(hs) * M6_W'(k)) begin
            q = q + 1'b1;
         end
      end
      if (hs == '0) begin
         idx = IDX_W'(TAPER_HALF);
      end else if (neg) begin
         idx = IDX_W'(TAPER_HALF) - IDX_W'(q);
      end else begin
         idx = IDX_W'(TAPER_HALF) + IDX_W'(q);
      end
      return taper_at(idx);
   endfunction

   assign take          = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !stg_valid_ff || out_ready;
   assign stg_valid_in  = take || (stg_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stg_x_ff    <= req_bus.pix_x;
         stg_y_ff    <= req_bus.pix_y;
         stg_r_ff    <= req_bus.red;
         stg_g_ff    <= req_bus.green;
         stg_b_ff    <= req_bus.blue;
         stg_last_ff <= req_bus.last_pixel;
      end
   end

   // percentage tests as cross products: floor(c*100/sum) against threshold
   assign sum   = SUM_W'(stg_r_ff) + SUM_W'(stg_g_ff) + SUM_W'(stg_b_ff);
   assign r100  = PCT_PROD_W'(stg_r_ff) * PCT_PROD_W'(100);
   assign g100  = PCT_PROD_W'(stg_g_ff) * PCT_PROD_W'(100);
   assign b100  = PCT_PROD_W'(stg_b_ff) * PCT_PROD_W'(100);
   assign r_lim = (PCT_PROD_W'(thr.red_pct_min) + 1'b1) * PCT_PROD_W'(sum);
   assign g_lim = PCT_PROD_W'(thr.green_pct_max) * PCT_PROD_W'(sum);
   assign b_lim = PCT_PROD_W'(thr.blue_pct_max) * PCT_PROD_W'(sum);

   assign wx = weight_at(stg_x_ff, center_x, half_span);
   assign wy = weight_at(stg_y_ff, center_y, half_span);

   assign out_valid = stg_valid_ff;
   assign out_hit   = (stg_r_ff > thr.red_min) && (sum != '0) && (r100 >= r_lim)
                      && (g100 < g_lim) && (b100 < b_lim);
   assign out_last  = stg_last_ff;
   assign out_x     = stg_x_ff;
   assign out_y     = stg_y_ff;
   assign out_red   = stg_r_ff;
   assign out_sum   = sum;
   assign out_wsum  = WSUM_W'(wx) + WSUM_W'(wy);
endmodule

FILE: hw/rtl/rese_back.sv
`timescale 1ns / 1ps
module rese_back #(
   parameter int COORD_W = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      in_hit,
   input  logic                      in_last,
   input  logic [COORD_W-1:0]        in_x,
   input  logic [COORD_W-1:0]        in_y,
   input  logic [rese_pkg::COLOR_W-1:0] in_red,
   input  logic [rese_pkg::SUM_W-1:0]   in_sum,
   input  logic [rese_pkg::WSUM_W-1:0]  in_wsum,
   rese_rsp_if.source                rsp_bus
);
   import rese_pkg::*;

   localparam int DVD_W = 2 * COLOR_W;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_UPD} state_type;

   state_type            state_ff;
   logic                 hit_ff, last_ff;
   logic [COORD_W-1:0]   x_ff, y_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [WSUM_W-1:0]    wsum_ff;
   logic [SUM_W-1:0]     rem_ff;
   logic [COLOR_W-1:0]   dvd_ff;
   logic [RATIO_W-1:0]   quo_ff;
   logic [2:0]           cnt_ff;
   logic [SCORE_W-1:0]   score_ff;
   logic [SCORE_W-1:0]   top_score_ff;
   logic [COORD_W-1:0]   top_x_ff, top_y_ff;
   logic                 any_hit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [SCORE_W-1:0]   rsp_score_ff;

   logic [DVD_W-1:0]     dividend;
   logic [SUM_W:0]       trial;
   logic                 trial_ge;
   logic [2*RATIO_W-1:0] product;
   logic                 better, out_free, upd_go, emit;
   logic [SCORE_W-1:0]   nxt_score;
   logic [COORD_W-1:0]   nxt_x, nxt_y;
   logic                 nxt_any;

   assign in_ready = (state_ff == ST_IDLE);
   // red*255 as a shift and subtract
   assign dividend = (DVD_W'(in_red) << COLOR_W) - DVD_W'(in_red);
   // restoring division, one quotient bit a cycle
   assign trial    = {rem_ff, dvd_ff[COLOR_W-1]};
   assign trial_ge = (trial >= (SUM_W + 1)'(sum_ff));
   assign product  = quo_ff * wsum_ff;

   assign better    = hit_ff && (score_ff > top_score_ff);
   assign nxt_score = better ? score_ff : top_score_ff;
   assign nxt_x     = better ? x_ff : top_x_ff;
   assign nxt_y     = better ? y_ff : top_y_ff;
   assign nxt_any   = better || any_hit_ff;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign upd_go    = !last_ff || out_free;
   assign emit      = (state_ff == ST_UPD) && upd_go && last_ff;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.best_x     = rsp_x_ff;
   assign rsp_bus.best_y     = rsp_y_ff;
   assign rsp_bus.best_score = rsp_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_score_ff <= '0;
         top_x_ff     <= '0;
         top_y_ff     <= '0;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result word register: load on emit, drop when taken
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  hit_ff  <= in_hit;
                  last_ff <= in_last;
                  x_ff    <= in_x;
                  y_ff    <= in_y;
                  sum_ff  <= in_sum;
                  wsum_ff <= in_wsum;
                  rem_ff  <= SUM_W'(dividend[DVD_W-1:COLOR_W]);
                  dvd_ff  <= dividend[COLOR_W-1:0];
                  cnt_ff  <= 3'd7;
                  state_ff <= in_hit ? ST_DIV : ST_UPD;
               end
            end
            ST_DIV: begin
               rem_ff <= trial_ge ? SUM_W'(trial - (SUM_W + 1)'(sum_ff)) : trial[SUM_W-1:0];
               quo_ff <= {quo_ff[RATIO_W-2:0], trial_ge};
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 3'd0) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               score_ff <= product[SCORE_W-1:0];
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (upd_go) begin
                  if (last_ff) begin
                     // emit the window result and start a fresh search
                     rsp_found_ff <= nxt_any;
                     rsp_x_ff     <= nxt_any ? nxt_x : '0;
                     rsp_y_ff     <= nxt_any ? nxt_y : '0;
                     rsp_score_ff <= nxt_any ? nxt_score : '0;
                     top_score_ff <= '0;
                     top_x_ff     <= '0;
                     top_y_ff     <= '0;
                     any_hit_ff   <= 1'b0;
                  end else begin
                     top_score_ff <= nxt_score;
                     top_x_ff     <= nxt_x;
                     top_y_ff     <= nxt_y;
                     any_hit_ff   <= nxt_any;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: hw/rtl/red_eye_seed_search.sv
`timescale 1ns / 1ps
// Red-eye seed search over one window of pixels.
// req_bus takes pixel words in raster order (x, y, RGB, last_pixel flag);
// rsp_bus gives one result word per window, after the pixel marked last:
// found, best_x, best_y, best_score (first strictly greatest score wins).
// csr_bus writes the centre, half span and color thresholds; the user must
// write registers only between windows, which the block does not enforce.
// A front stage registers each pixel and classifies it (color tests and the
// taper weights), then a two-entry queue feeds the back end, which scores it.
// The back end handles one pixel at a time: a non-qualifying pixel goes from
// capture straight to the update; a qualifying one passes through capture, the
// bit-serial divider for red*255/(R+G+B), a multiply and the update.
// The result sits in an output register; the back end keeps working while it
// waits, and stalls only when a second result is due before the first is taken.
// Synchronous reset restores the default thresholds, clears the centre and
// half span, empties the queue and clears the running best.
module red_eye_seed_search #(
   parameter int MAX_SIDE = rese_pkg::MAX_SIDE_DEF
) (
   input logic        clock,
   input logic        reset,
   rese_req_if.sink   req_bus,
   rese_rsp_if.source rsp_bus,
   rese_csr_if.sink   csr_bus
);
   import rese_pkg::*;

   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int ITEM_W  = 2 + 2 * COORD_W + COLOR_W + SUM_W + WSUM_W;

   logic [COORD_W-1:0] center_x_ff, center_y_ff, half_span_ff;
   rese_thr_type       thr_ff;
   logic               csr_take;

   logic               f_valid, f_ready, f_hit, f_last;
   logic [COORD_W-1:0] f_x, f_y;
   logic [COLOR_W-1:0] f_red;
   logic [SUM_W-1:0]   f_sum;
   logic [WSUM_W-1:0]  f_wsum;
   logic [ITEM_W-1:0]  q_in, q_out;
   logic               q_valid, q_ready;

   assign csr_bus.ready = 1'b1;
   assign csr_take      = csr_bus.valid && csr_bus.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff        <= '0;
         center_y_ff        <= '0;
         half_span_ff       <= '0;
         thr_ff.red_min       <= RED_MIN_RST;
         thr_ff.red_pct_min   <= RED_PCT_MIN_RST;
         thr_ff.green_pct_max <= GREEN_PCT_MAX_RST;
         thr_ff.blue_pct_max  <= BLUE_PCT_MAX_RST;
      end else if (csr_take) begin
         unique case (csr_bus.addr)
            REG_CENTER_X:      center_x_ff  <= csr_bus.wdata[COORD_W-1:0];
            REG_CENTER_Y:      center_y_ff  <= csr_bus.wdata[COORD_W-1:0];
            REG_HALF_SPAN:     half_span_ff <= csr_bus.wdata[COORD_W-1:0];
            REG_RED_MIN:       thr_ff.red_min       <= csr_bus.wdata[COLOR_W-1:0];
            REG_RED_PCT_MIN:   thr_ff.red_pct_min   <= csr_bus.wdata[PCT_W-1:0];
            REG_GREEN_PCT_MAX: thr_ff.green_pct_max <= csr_bus.wdata[PCT_W-1:0];
            REG_BLUE_PCT_MAX:  thr_ff.blue_pct_max  <= csr_bus.wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   rese_front #(.COORD_W(COORD_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .thr       (thr_ff),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .half_span (half_span_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_hit   (f_hit),
      .out_last  (f_last),
      .out_x     (f_x),
      .out_y     (f_y),
      .out_red   (f_red),
      .out_sum   (f_sum),
      .out_wsum  (f_wsum)
   );

   assign q_in = {f_hit, f_last, f_x, f_y, f_red, f_sum, f_wsum};

   rese_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out)
   );

   rese_back #(.COORD_W(COORD_W)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_hit   (q_out[ITEM_W-1]),
      .in_last  (q_out[ITEM_W-2]),
      .in_x     (q_out[ITEM_W-3 -: COORD_W]),
      .in_y     (q_out[ITEM_W-3-COORD_W -: COORD_W]),
      .in_red   (q_out[SUM_W+WSUM_W +: COLOR_W]),
      .in_sum   (q_out[WSUM_W +: SUM_W]),
      .in_wsum  (q_out[WSUM_W-1:0]),
      .rsp_bus  (rsp_bus)
   );
endmodule

FILE: tb/rese_seed_checker.sv
`timescale 1ns / 1ps
module rese_seed_checker (
   input  logic       clock,
   input  logic       reset,
   rese_req_if.sink   req_mon,
   rese_rsp_if.sink   rsp_mon,
   rese_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending,
   output int         windows_seen,
   output int         hits_seen
);
   import rese_pkg::*;

   typedef struct packed {
      logic        found;
      logic [11:0] bx;
      logic [11:0] by;
      logic [14:0] score;
   } seed_type;

   // shadow registers
   logic [11:0] ctr_x, ctr_y, span;
   logic [7:0]  rmin;
   logic [6:0]  rpct, gpct, bpct;
   // running best of the current window
   logic [14:0] top_score;
   logic [11:0] top_x, top_y;
   logic        any_hit;
   seed_type    seed_q[$];

   function automatic int taper_weight(int pos, int ctr, int hs);
      int tbl[13] = '{28, 39, 48, 55, 60, 63, 64, 63, 60, 55, 48, 39, 28};
      int idx;
      if (hs == 0) return 64;
      idx = (6 * (pos - ctr)) / hs + 6; // SV int division truncates toward zero
      if (idx < 0) idx = 0;
      if (idx > 12) idx = 12;
      return tbl[idx];
   endfunction

   always @(posedge clock) begin
      int r, g, b, s, sc;
      seed_type exp_w, got;
      if (reset) begin
         ctr_x <= '0; ctr_y <= '0; span <= '0;
         rmin <= RED_MIN_RST; rpct <= RED_PCT_MIN_RST;
         gpct <= GREEN_PCT_MAX_RST; bpct <= BLUE_PCT_MAX_RST;
         top_score = '0; top_x = '0; top_y = '0; any_hit = 1'b0;
         seed_q.delete();
         pending <= 0;
         fail_count <= 0; windows_seen <= 0; hits_seen <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               REG_CENTER_X:      ctr_x <= csr_mon.wdata[11:0];
               REG_CENTER_Y:      ctr_y <= csr_mon.wdata[11:0];
               REG_HALF_SPAN:     span  <= csr_mon.wdata[11:0];
               REG_RED_MIN:       rmin  <= csr_mon.wdata[7:0];
               REG_RED_PCT_MIN:   rpct  <= csr_mon.wdata[6:0];
               REG_GREEN_PCT_MAX: gpct  <= csr_mon.wdata[6:0];
               REG_BLUE_PCT_MAX:  bpct  <= csr_mon.wdata[6:0];
               default: ;
            endcase
         end
         // pixel word: score and track the best
         if (req_mon.valid && req_mon.ready) begin
            r = int'(req_mon.red); g = int'(req_mon.green); b = int'(req_mon.blue);
            s = r + g + b;
            if (r > int'(rmin) && s != 0 && (r * 100) / s > int'(rpct)
                && (g * 100) / s < int'(gpct) && (b * 100) / s < int'(bpct)) begin
               sc = ((r * 255) / s)
                    * (taper_weight(int'(req_mon.pix_x), int'(ctr_x), int'(span))
                    + taper_weight(int'(req_mon.pix_y), int'(ctr_y), int'(span)));
               if (sc > int'(top_score)) begin
                  top_score = sc[14:0];
                  top_x = req_mon.pix_x; top_y = req_mon.pix_y;
                  any_hit = 1'b1;
               end
            end
            if (req_mon.last_pixel) begin
               exp_w.found = any_hit;
               exp_w.bx    = any_hit ? top_x : '0;
               exp_w.by    = any_hit ? top_y : '0;
               exp_w.score = any_hit ? top_score : '0;
               seed_q.push_back(exp_w);
               top_score = '0; top_x = '0; top_y = '0; any_hit = 1'b0;
            end
         end
         // result word: compare against oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.found, rsp_mon.best_x, rsp_mon.best_y, rsp_mon.best_score};
            windows_seen <= windows_seen + 1;
            if (got.found) hits_seen <= hits_seen + 1;
            if (seed_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %p", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = seed_q.pop_front();
               if (got !== exp_w) begin
                  if (fail_count < 10) begin
                     $display("mismatch: exp found=%0d x=%0d y=%0d score=%0d",
                        exp_w.found, exp_w.bx, exp_w.by, exp_w.score);
                     $display("          got found=%0d x=%0d y=%0d score=%0d",
                        got.found, got.bx, got.by, got.score);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= seed_q.size();
      end
   end
endmodule

FILE: tb/tb_red_eye_seed_search.sv
`timescale 1ns / 1ps
module tb_red_eye_seed_search;
   import rese_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, windows_seen, hits_seen;
   bit   calm;
   int   win_count;

   rese_req_if req_bus ();
   rese_rsp_if rsp_bus ();
   rese_csr_if csr_bus ();

   red_eye_seed_search dut (.clock(clock), .reset(reset), .req_bus(req_bus),
      .rsp_bus(rsp_bus), .csr_bus(csr_bus));

   rese_seed_checker u_chk (.clock(clock), .reset(reset), .req_mon(req_bus),
      .rsp_mon(rsp_bus), .csr_mon(csr_bus), .fail_count(fail_count),
      .pending(pending), .windows_seen(windows_seen), .hits_seen(hits_seen));

   always #5 clock = ~clock;

   // result-side stalls in bursts
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            rsp_bus.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input int v);
      csr_bus.addr <= a; csr_bus.wdata <= v[CSR_DATA_W-1:0]; csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // drain outstanding results, then let the back end settle
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic send_pixel(input int x, input int y, input int r, input int g,
                             input int b, input bit last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.pix_x <= 12'(x); req_bus.pix_y <= 12'(y); req_bus.red <= 8'(r);
      req_bus.green <= 8'(g); req_bus.blue <= 8'(b); req_bus.last_pixel <= last;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic end_stream();
      req_bus.valid <= 1'b0;
   endtask

   // random window in raster order; mostly reddish pixels around the centre
   task automatic send_window(input int cx, input int cy, input int hs);
      int w, h, x0, y0, r, g, b;
      w = $urandom_range(1, 6); h = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) begin
         x0 = $urandom_range(0, 4095 - w); y0 = $urandom_range(0, 4095 - h);
      end else begin
         x0 = cx - w / 2 - $urandom_range(0, 2 * hs + 2);
         y0 = cy - h / 2 - $urandom_range(0, 2 * hs + 2);
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x0 > 4095 - w) x0 = 4095 - w;
         if (y0 > 4095 - h) y0 = 4095 - h;
      end
      for (int j = 0; j < h; j++)
         for (int i = 0; i < w; i++) begin
            if ($urandom_range(0, 2) != 0) begin
               r = $urandom_range(60, 255); g = $urandom_range(0, r / 3);
               b = $urandom_range(0, r / 3);
            end else begin
               r = $urandom_range(0, 255); g = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
            end
            send_pixel(x0 + i, y0 + j, r, g, b, (i == w - 1) && (j == h - 1));
         end
      win_count++;
   endtask

   task automatic set_thresholds(input int rm, input int rp, input int gp, input int bp);
      csr_write(REG_RED_MIN, rm); csr_write(REG_RED_PCT_MIN, rp);
      csr_write(REG_GREEN_PCT_MAX, gp); csr_write(REG_BLUE_PCT_MAX, bp);
   endtask

   initial begin
      int cx, cy, hs, items;
      req_bus.valid = 0; req_bus.pix_x = 0; req_bus.pix_y = 0;
      req_bus.red = 0; req_bus.green = 0; req_bus.blue = 0; req_bus.last_pixel = 0;
      csr_bus.valid = 0; csr_bus.addr = REG_CENTER_X; csr_bus.wdata = 0;
      calm = 0; win_count = 0; items = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset thresholds, zero span, extremes
      send_pixel(0, 0, 0, 0, 0, 1);                     // black, nothing found
      send_pixel(4095, 4095, 255, 0, 0, 0);             // max red
      send_pixel(0, 0, 255, 0, 0, 0);                   // tie, earlier kept
      send_pixel(100, 100, 51, 10, 10, 1);
      send_pixel(5, 5, 255, 255, 255, 1);               // gray, fails
      send_pixel(7, 7, 50, 0, 0, 1);                    // red at min, fails
      end_stream(); settle();
      csr_write(REG_CENTER_X, 2048); csr_write(REG_CENTER_Y, 2048);
      csr_write(REG_HALF_SPAN, 1);
      send_pixel(0, 0, 200, 10, 10, 0);                 // clamp low
      send_pixel(4095, 4095, 200, 10, 10, 0);           // clamp high
      send_pixel(2048, 2048, 200, 10, 10, 0);           // centre
      send_pixel(2047, 2049, 200, 10, 10, 1);
      end_stream(); settle();
      csr_write(REG_HALF_SPAN, 2048);
      set_thresholds(255, 127, 0, 0);                   // nothing can qualify
      send_pixel(4095, 0, 255, 0, 0, 1);
      end_stream(); settle();
      set_thresholds(0, 0, 127, 127);                   // nearly everything qualifies
      send_pixel(0, 4095, 1, 0, 0, 0);
      send_pixel(4095, 0, 1, 255, 255, 0);
      send_pixel(2048, 2048, 128, 127, 127, 1);
      send_pixel(1234, 2345, 170, 85, 85, 1);
      end_stream(); settle();

      // random phases with various settings
      for (int ph = 0; ph < 16; ph++) begin
         cx = $urandom_range(0, 4095); cy = $urandom_range(0, 4095);
         case (ph % 4)
            0: hs = 0;
            1: hs = $urandom_range(1, 8);
            2: hs = $urandom_range(9, 300);
            default: hs = 2048;
         endcase
         csr_write(REG_CENTER_X, cx); csr_write(REG_CENTER_Y, cy);
         csr_write(REG_HALF_SPAN, hs);
         if (ph % 5 == 4) set_thresholds($urandom_range(0, 255), $urandom_range(0, 127),
                                          $urandom_range(0, 127), $urandom_range(0, 127));
         else set_thresholds($urandom_range(0, 80), $urandom_range(20, 50),
                             $urandom_range(25, 60), $urandom_range(25, 60));
         calm = (ph >= 14);
         repeat (14) send_window(cx, cy, hs);
         end_stream(); settle();
      end

      $display("covered %0d windows over 16 register settings plus directed cases;",
               win_count);
      $display("%0d result words checked, %0d with a red-eye seed", windows_seen, hits_seen);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/rese_pkg.sv
hw/rtl/rese_req_if.sv
hw/rtl/rese_rsp_if.sv
hw/rtl/rese_csr_if.sv
hw/rtl/rese_fifo.sv
hw/rtl/rese_front.sv
hw/rtl/rese_back.sv
hw/rtl/red_eye_seed_search.sv
tb/rese_seed_checker.sv
tb/tb_red_eye_seed_search.sv
